@@ rtl/core/fnms_pkg.sv @@
// Shared constants and types for the Fitch node merge and score block.
// No dependencies.
package fnms_pkg;

  localparam int unsigned SiteW   = 12;
  localparam int unsigned Sites   = 4096;
  localparam int unsigned SetW    = 32;
  localparam int unsigned WeightW = 32;
  localparam int unsigned ScoreW  = 40;
  localparam int unsigned CountW  = 16;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InDataRawW  = SiteW + 2 * SetW + WeightW + ScoreW;
  localparam int unsigned InDataW     = ((InDataRawW + 7) / 8) * 8;
  localparam int unsigned OutDataRawW = SetW + ScoreW + CountW;
  localparam int unsigned OutDataW    = ((OutDataRawW + 7) / 8) * 8;

  // One input request held in the work stage
  typedef struct packed {
    logic [SiteW-1:0]   site;
    logic [SetW-1:0]    left_set;
    logic [SetW-1:0]    right_set;
    logic [WeightW-1:0] weight;
    logic [ScoreW-1:0]  base_score;
    logic               first_site;
    logic               last_site;
  } item_t;

  // One result held in the output register
  typedef struct packed {
    logic [SetW-1:0]   parent_set;
    logic              changed;
    logic [ScoreW-1:0] score;
    logic [CountW-1:0] site_changes;
    logic              last;
  } result_t;

endpackage

@@ rtl/core/fitch_node_merge_score.sv @@
// Fitch parsimony merge of two child state sets with saturating weighted score
// and per-site change counters. Depends on fnms_pkg.
//
// Stages: input register, then result register; each holds while the output
// stalls. Throughput: one request per cycle unless the output stalls; the
// counter store is read-modify-written once per cycle, with forwarding for
// back-to-back requests on the same site.
// Reset: control state clears at once; then a clearing pass zeroes the
// counter store, one entry per cycle, with s_axis_tready held low.
module fitch_node_merge_score (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration: bit 0 = count_per_site
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_data_i,
  // Input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: site, left_set, right_set, weight, base_score, zero pad
  input  logic [fnms_pkg::InDataW-1:0]     s_axis_tdata,
  // tuser: first_site
  input  logic                             s_axis_tuser,
  // tlast: last_site
  input  logic                             s_axis_tlast,
  // Output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: parent_set, score, site_changes
  output logic [fnms_pkg::OutDataW-1:0]    m_axis_tdata,
  // tuser: changed
  output logic                             m_axis_tuser,
  // tlast: last
  output logic                             m_axis_tlast
);
  import fnms_pkg::*;

  localparam int unsigned LeftLo   = SiteW;
  localparam int unsigned RightLo  = LeftLo + SetW;
  localparam int unsigned WeightLo = RightLo + SetW;
  localparam int unsigned BaseLo   = WeightLo + WeightW;

  // Counter store and clearing pass
  logic [CountW-1:0] cnt_mem [Sites];
  logic              clr_busy_q;
  logic [SiteW-1:0]  clr_addr_q;

  // Control and stage registers
  logic              cnt_en_q;
  logic              s1_valid_q;
  item_t             s1_q;
  logic [CountW-1:0] rd_data_q;
  logic              fwd_hit_q;
  logic [CountW-1:0] fwd_data_q;
  logic [ScoreW-1:0] score_q;
  logic              out_valid_q;
  result_t           out_q;

  item_t             in_item;
  logic              in_fire;
  logic              s1_adv;
  logic              wr_en;
  logic [SiteW-1:0]  wr_addr;
  logic [CountW-1:0] wr_data;
  logic [SetW-1:0]   and_set;
  logic              changed;
  logic [ScoreW-1:0] score_base;
  logic [ScoreW:0]   score_sum;
  logic [ScoreW-1:0] score_d;
  logic [CountW-1:0] cnt_cur;
  logic              cnt_inc;
  logic [CountW-1:0] cnt_d;
  result_t           res_d;

  // Unpack the input request
  always_comb begin
    in_item.site       = s_axis_tdata[LeftLo-1:0];
    in_item.left_set   = s_axis_tdata[RightLo-1:LeftLo];
    in_item.right_set  = s_axis_tdata[WeightLo-1:RightLo];
    in_item.weight     = s_axis_tdata[BaseLo-1:WeightLo];
    in_item.base_score = s_axis_tdata[BaseLo+ScoreW-1:BaseLo];
    in_item.first_site = s_axis_tuser;
    in_item.last_site  = s_axis_tlast;
  end

  // Handshakes
  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Merge, score and count update for the item in the work stage
  always_comb begin
    and_set    = s1_q.left_set & s1_q.right_set;
    changed    = (and_set == '0);
    score_base = s1_q.first_site ? s1_q.base_score : score_q;
    score_sum  = {1'b0, score_base} + {{(ScoreW + 1 - WeightW){1'b0}}, s1_q.weight};
    if (!changed) begin
      score_d = score_base;
    end else if (score_sum[ScoreW]) begin
      score_d = '1;
    end else begin
      score_d = score_sum[ScoreW-1:0];
    end
    cnt_cur = fwd_hit_q ? fwd_data_q : rd_data_q;
    cnt_inc = changed && cnt_en_q && (cnt_cur != '1);
    cnt_d   = cnt_cur + {{(CountW - 1){1'b0}}, cnt_inc};

    res_d.parent_set   = changed ? (s1_q.left_set | s1_q.right_set) : and_set;
    res_d.changed      = changed;
    res_d.score        = score_d;
    res_d.site_changes = cnt_d;
    res_d.last         = s1_q.last_site;
  end

  // Store write port: clearing pass, else write-back of the retiring item
  always_comb begin
    wr_en   = clr_busy_q || s1_adv;
    wr_addr = clr_busy_q ? clr_addr_q : s1_q.site;
    wr_data = clr_busy_q ? '0 : cnt_d;
  end

  // Counter store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cnt_mem[wr_addr] <= wr_data;
    end
    if (in_fire) begin
      rd_data_q <= cnt_mem[in_item.site];
    end
  end

  // Forward a same-cycle write-back to the newly accepted item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fwd_hit_q  <= s1_adv && (s1_q.site == in_item.site);
      fwd_data_q <= cnt_d;
      s1_q       <= in_item;
    end
    if (s1_adv) begin
      out_q <= res_d;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      cnt_en_q    <= 1'b1;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      score_q     <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == SiteW'(Sites - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cnt_en_q <= cfg_data_i;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        score_q     <= score_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pack the result
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.changed;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = OutDataW'({out_q.site_changes, out_q.score, out_q.parent_set});

endmodule

@@ tb/tb_fitch_node_merge_score.sv @@
// Testbench for fitch_node_merge_score: stream stimulus, a running prediction
// of parent sets, scores and site change counts, checked result by result.
// Depends on fnms_pkg and the fitch_node_merge_score RTL.
`timescale 1ns / 1ps

module tb_fitch_node_merge_score;
  import fnms_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned BurstItems = 24;
  localparam logic [SiteW-1:0] BurstSite = 12'd9;

  // Tracks the block's state and queues the results each request should give
  class parsimony_tracker;
    logic [ScoreW-1:0] score_acc;
    logic [CountW-1:0] change_count [Sites];
    bit                count_sites;
    result_t           pending_results[$];
    int unsigned       errors;

    function new();
      score_acc   = '0;
      count_sites = 1'b1;
      errors      = 0;
      foreach (change_count[i]) change_count[i] = '0;
    endfunction

    function void set_count_mode(bit on);
      count_sites = on;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // Fitch merge, saturating score add and counter update for one request
    function void note_request(item_t req);
      result_t         res;
      logic [SetW-1:0] meet;
      logic [ScoreW:0] sum;
      logic [CountW-1:0] cnt;
      if (req.first_site) score_acc = req.base_score;
      meet = req.left_set & req.right_set;
      res.changed = (meet == '0);
      if (res.changed) begin
        res.parent_set = req.left_set | req.right_set;
        sum = {1'b0, score_acc} + {{(ScoreW - WeightW + 1){1'b0}}, req.weight};
        score_acc = sum[ScoreW] ? '1 : sum[ScoreW-1:0];
      end else begin
        res.parent_set = meet;
      end
      cnt = '0;
      if (req.site < Sites) begin
        cnt = change_count[req.site];
        if (res.changed && count_sites && cnt != '1) begin
          cnt = cnt + 1'b1;
          change_count[req.site] = cnt;
        end
      end
      res.score        = score_acc;
      res.site_changes = cnt;
      res.last         = req.last_site;
      pending_results.push_back(res);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: parent %h score %h count %h",
                   got.parent_set, got.score, got.site_changes);
        return;
      end
      want = pending_results.pop_front();
      if (got.parent_set !== want.parent_set || got.changed !== want.changed ||
          got.score !== want.score || got.site_changes !== want.site_changes ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("bad result: parent exp %h got %h, changed exp %b got %b",
                   want.parent_set, got.parent_set, want.changed, got.changed);
          $display("  score exp %h got %h, count exp %h got %h, last exp %b got %b",
                   want.score, got.score, want.site_changes, got.site_changes,
                   want.last, got.last);
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic                cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  parsimony_tracker tracker = new();
  bit               gaps_on   = 1'b1;
  bit               stalls_on = 1'b1;
  int unsigned      cycles    = 0;

  fitch_node_merge_score dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // site, left_set, right_set, weight, base_score
    .s_axis_tuser  (s_axis_tuser),   // first_site
    .s_axis_tlast  (s_axis_tlast),   // last_site
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // parent_set, score, site_changes
    .m_axis_tuser  (m_axis_tuser),   // changed
    .m_axis_tlast  (m_axis_tlast)    // last
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("fitch_node_merge_score: mismatch");
      $finish;
    end
  end

  function automatic item_t mk_item(logic [SiteW-1:0] site, logic [SetW-1:0] lset,
                                    logic [SetW-1:0] rset, logic [WeightW-1:0] w,
                                    logic [ScoreW-1:0] base, bit first, bit last);
    item_t req;
    req.site       = site;
    req.left_set   = lset;
    req.right_set  = rset;
    req.weight     = w;
    req.base_score = base;
    req.first_site = first;
    req.last_site  = last;
    return req;
  endfunction

  // Mostly small nucleotide-like sets, with empty, full and wide random ones
  function automatic logic [SetW-1:0] rand_set();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return $urandom();
      2:       return '1;
      3:       return 32'h1 << $urandom_range(0, SetW - 1);
      default: return $urandom_range(1, 15);
    endcase
  endfunction

  function automatic logic [WeightW-1:0] rand_weight();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return '1;
      2:       return '0;
      default: return WeightW'($urandom_range(1, 4)) << 8;
    endcase
  endfunction

  function automatic logic [ScoreW-1:0] rand_base();
    case ($urandom_range(0, 5))
      0:       return ScoreW'({$urandom(), $urandom()});
      1:       return '1 - ScoreW'($urandom_range(0, 2000));
      2:       return '0;
      default: return ScoreW'($urandom_range(0, 65535));
    endcase
  endfunction

  // One request on the input stream, after a random gap
  task automatic push_request(item_t req);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({req.base_score, req.weight, req.right_set,
                               req.left_set, req.site});
    s_axis_tuser  <= req.first_site;
    s_axis_tlast  <= req.last_site;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_request(req);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Register write once the block has gone idle
  task automatic write_count_mode(bit on);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= on;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.set_count_mode(on);
  endtask

  // Nodes of random length, well formed apart from some stray flags
  task automatic run_nodes(int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    item_t       req;
    sent = 0;
    while (sent < n_items) begin
      len       = $urandom_range(1, 8);
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      for (int unsigned i = 0; i < len; i++) begin
        req = mk_item($urandom_range(0, 1) ? SiteW'($urandom_range(0, 15))
                                           : SiteW'($urandom()),
                      rand_set(), rand_set(), rand_weight(), rand_base(),
                      i == 0, i == len - 1);
        if ($urandom_range(0, 9) == 0) begin
          req.first_site = 1'($urandom_range(0, 1));
          req.last_site  = 1'($urandom_range(0, 1));
        end
        push_request(req);
        sent++;
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Output side: random stall, then take one result
  initial begin
    int unsigned stall;
    result_t     got;
    m_axis_tready = 1'b0;
    forever begin
      stall = stalls_on ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.parent_set   = m_axis_tdata[SetW-1:0];
      got.score        = m_axis_tdata[SetW +: ScoreW];
      got.site_changes = m_axis_tdata[SetW + ScoreW +: CountW];
      got.changed      = m_axis_tuser;
      got.last         = m_axis_tlast;
      tracker.check_result(got);
    end
  end

  // Main sequence
  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_count_mode(1'b1);

    // Directed: empty sets, full sets, score saturation, same-site runs
    push_request(mk_item(12'd0,    '0, '0, '1, '0, 1, 0));
    push_request(mk_item(12'd4095, '1, '1, '1, '0, 0, 1));
    push_request(mk_item(12'd1, 32'h0000_FFFF, 32'hFFFF_0000, 32'h100, '1, 1, 0));
    push_request(mk_item(12'd2, 32'h1, 32'h0, 32'h1, '0, 0, 1));
    push_request(mk_item(12'd3, 32'h8000_0001, 32'h8000_0000, '1,
                         40'hFF_FFFF_FF00, 1, 1));
    push_request(mk_item(12'd3, 32'h2, 32'h4, 32'hFF, '0, 1'b0, 1'b0));
    push_request(mk_item(12'd3, 32'h4, 32'h8, 32'h1, '0, 0, 1));
    push_request(mk_item(12'd5, 32'h1, 32'h2, 32'h0, '0, 1, 0));
    push_request(mk_item(12'd5, 32'h3, 32'hC, 32'h180, '0, 0, 0));
    push_request(mk_item(12'd5, 32'h0, 32'h5, 32'h7FFF_FFFF, '0, 0, 0));
    push_request(mk_item(12'd5, 32'h6, 32'h2, 32'h200, '0, 0, 1));
    push_request(mk_item(12'd4095, 32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678,
                         40'h12_3456_789A, 1, 1));
    push_request(mk_item(12'd4095, 32'h0, 32'hFFFF_FFFF, '0, '0, 1, 1));

    run_nodes(250);

    // Counting off: counters hold, score still accumulates
    write_count_mode(1'b0);
    push_request(mk_item(12'd5, 32'h1, 32'h2, 32'h100, '0, 1, 1));
    run_nodes(250);

    write_count_mode(1'b1);
    run_nodes(100);
    drain();
    run_nodes(100);

    // Unbroken back-to-back run of changes on one site
    drain();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    for (int unsigned i = 0; i < BurstItems; i++)
      push_request(mk_item(BurstSite, 32'h1, 32'h2, 32'h1, '0, i == 0,
                           i == BurstItems - 1));
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    write_count_mode(1'b0);
    push_request(mk_item(BurstSite, 32'h10, 32'h20, 32'h100, '0, 1, 0));
    write_count_mode(1'b1);
    push_request(mk_item(BurstSite, 32'h10, 32'h20, 32'h100, '0, 0, 1));

    drain();
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("fitch_node_merge_score: match");
    else
      $display("fitch_node_merge_score: mismatch");
    $finish;
  end

endmodule
